>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for clocked properties with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/tca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_pkg
// Shared types and constants of the task CPU time accounting block.
// ----------------------------------------------------------------------------
package tca_pkg;

   localparam int TASK_SLOTS_DEFAULT = 1024;

   localparam int KIND_W      = 2;
   localparam int STAMP_W     = 64;
   localparam int ID_W        = 10;
   localparam int TOTAL_W     = 64;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 256;

   localparam logic [KIND_W-1:0] KIND_WAKE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SWITCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   typedef struct packed {
      logic [TOTAL_W-1:0] wait_tally;
      logic [TOTAL_W-1:0] run_tally;
      logic [TOTAL_W-1:0] wait_sum;
      logic [TOTAL_W-1:0] run_sum;
      logic               wake_held;
      logic [STAMP_W-1:0] wake_time;
      logic               start_held;
      logic [STAMP_W-1:0] start_time;
   } row_type;

endpackage

>>> hw/rtl/tca_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_alu
// Shared 64-bit add / subtract unit with a registered result.
// ----------------------------------------------------------------------------
module tca_alu (
   input  logic                        clock,
   input  logic                        op_sub,
   input  logic [tca_pkg::STAMP_W-1:0] opa,
   input  logic [tca_pkg::STAMP_W-1:0] opb,
   output logic [tca_pkg::STAMP_W-1:0] result
);
   import tca_pkg::*;

   logic [STAMP_W-1:0] result_ff;
   logic [STAMP_W-1:0] result_in;

   always_comb begin
      if (op_sub) begin
         result_in = opa - opb;
      end else begin
         result_in = opa + opb;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

>>> hw/rtl/tca_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_mem
// Per-slot record store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tca_mem #(
   parameter int TASK_SLOTS = tca_pkg::TASK_SLOTS_DEFAULT,
   parameter int IDX_W      = $clog2(TASK_SLOTS)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  tca_pkg::row_type wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output tca_pkg::row_type rd_data
);
   import tca_pkg::*;

   row_type mem [TASK_SLOTS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/task_cpu_time_accounting_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_cpu_time_accounting_top
// Per-task on-CPU and runqueue latency accounting over a slot record store.
//
//   channel  | dir | tdata                                   | tuser
//   req_     | in  | stamp[63:0] task_id[73:64] incoming[83:74] | kind[1:0]
//   rsp_     | out | on_cpu, queue_wait, burst, wait (64 each) | -
//
// A wakeup reads its slot, updates it and writes it back; a read loads its
// slot and then responds. A switch makes up to two read-modify-write passes
// over the record store, with up to three uses of the shared adder each.
// After reset a clearing pass writes zero to every slot with req_tready low.
// A read waits in place while an earlier result is still held on the rsp_ side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module task_cpu_time_accounting_top #(
   parameter int TASK_SLOTS = tca_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // stamp [63:0], task_id [73:64], incoming_id [83:74], zero fill
   input  logic [tca_pkg::REQ_TDATA_W-1:0] req_tdata,
   // kind [1:0]
   input  logic [tca_pkg::KIND_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // on_cpu_total [63:0], queue_wait_total [127:64],
   // burst_count [191:128], wait_count [255:192]
   output logic [tca_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import tca_pkg::*;

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_SLOTS - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_LOAD  = 4'd3;
   localparam logic [3:0] S_SUB   = 4'd4;
   localparam logic [3:0] S_ADDS  = 4'd5;
   localparam logic [3:0] S_ADDT  = 4'd6;
   localparam logic [3:0] S_TALW  = 4'd7;
   localparam logic [3:0] S_WRITE = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   logic [3:0]             state_ff, state_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;
   logic [KIND_W-1:0]      kind_ff, kind_in;
   logic [STAMP_W-1:0]     stamp_ff, stamp_in;
   logic [ID_W-1:0]        inc_ff, inc_in;
   logic                   in_phase_ff, in_phase_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   row_type                row_ff, row_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [STAMP_W-1:0] req_stamp;
   logic [ID_W-1:0]    req_id;
   logic [ID_W-1:0]    req_inc;
   logic               req_id_ok;
   logic               req_inc_ok;
   logic               inc_ok;
   logic               accept;

   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   row_type            mem_wr_data;
   row_type            mem_rd_data;

   logic               alu_sub;
   logic [STAMP_W-1:0] alu_a;
   logic [STAMP_W-1:0] alu_b;
   logic [STAMP_W-1:0] alu_y;

   assign req_stamp  = req_tdata[63:0];
   assign req_id     = req_tdata[73:64];
   assign req_inc    = req_tdata[83:74];
   assign req_id_ok  = 32'(req_id) < TASK_SLOTS;
   assign req_inc_ok = 32'(req_inc) < TASK_SLOTS;
   assign inc_ok     = 32'(inc_ff) < TASK_SLOTS;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   tca_mem #(
      .TASK_SLOTS (TASK_SLOTS),
      .IDX_W      (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (state_ff == S_READ),
      .rd_addr (cur_ff),
      .rd_data (mem_rd_data)
   );

   tca_alu u_alu (
      .clock  (clock),
      .op_sub (alu_sub),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_y)
   );

   always_comb begin
      mem_wr_en   = (state_ff == S_CLEAR) || (state_ff == S_WRITE);
      mem_wr_addr = (state_ff == S_CLEAR) ? clr_ff : cur_ff;
      mem_wr_data = (state_ff == S_CLEAR) ? '0 : row_ff;
   end

   // operand select for the shared adder
   always_comb begin
      alu_sub = 1'b0;
      alu_a   = alu_y;
      alu_b   = alu_y;
      unique case (state_ff)
         S_SUB: begin
            alu_sub = 1'b1;
            alu_a   = stamp_ff;
            alu_b   = in_phase_ff ? row_ff.wake_time : row_ff.start_time;
         end
         S_ADDS: begin
            alu_a = in_phase_ff ? row_ff.wait_sum : row_ff.run_sum;
            alu_b = alu_y;
         end
         S_ADDT: begin
            alu_a = in_phase_ff ? row_ff.wait_tally : row_ff.run_tally;
            alu_b = STAMP_W'(1);
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      kind_in      = kind_ff;
      stamp_in     = stamp_ff;
      inc_in       = inc_ff;
      in_phase_in  = in_phase_ff;
      cur_in       = cur_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               kind_in     = req_tuser;
               stamp_in    = req_stamp;
               inc_in      = req_inc;
               in_phase_in = 1'b0;
               cur_in      = IDX_W'(req_id);
               row_in      = '0;
               case (req_tuser)
                  KIND_WAKE: begin
                     state_in = req_id_ok ? S_READ : S_IDLE;
                  end
                  KIND_READ: begin
                     state_in = req_id_ok ? S_READ : S_RESP;
                  end
                  KIND_SWITCH: begin
                     if (req_id_ok) begin
                        state_in = S_READ;
                     end else if (req_inc_ok) begin
                        in_phase_in = 1'b1;
                        cur_in      = IDX_W'(req_inc);
                        state_in    = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            row_in   = mem_rd_data;
            state_in = S_WRITE;
            case (kind_ff)
               KIND_WAKE: begin
                  row_in.wake_time = stamp_ff;
                  row_in.wake_held = 1'b1;
               end
               KIND_READ: begin
                  state_in = S_RESP;
               end
               default: begin
                  if (in_phase_ff) begin
                     row_in.start_time = stamp_ff;
                     row_in.start_held = 1'b1;
                     if (mem_rd_data.wake_held) begin
                        state_in = S_SUB;
                     end
                  end else if (mem_rd_data.start_held) begin
                     state_in = S_SUB;
                  end
               end
            endcase
         end
         S_SUB: begin
            if (in_phase_ff) begin
               row_in.wake_held = 1'b0;
            end else begin
               row_in.start_held = 1'b0;
            end
            state_in = S_ADDS;
         end
         S_ADDS: begin
            state_in = alu_y[STAMP_W-1] ? S_WRITE : S_ADDT;
         end
         S_ADDT: begin
            if (in_phase_ff) begin
               row_in.wait_sum = alu_y;
            end else begin
               row_in.run_sum = alu_y;
            end
            state_in = S_TALW;
         end
         S_TALW: begin
            if (in_phase_ff) begin
               row_in.wait_tally = alu_y;
            end else begin
               row_in.run_tally = alu_y;
            end
            state_in = S_WRITE;
         end
         S_WRITE: begin
            state_in = S_IDLE;
            if ((kind_ff == KIND_SWITCH) && !in_phase_ff && inc_ok) begin
               in_phase_in = 1'b1;
               cur_in      = IDX_W'(inc_ff);
               state_in    = S_READ;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {row_ff.wait_tally, row_ff.run_tally,
                               row_ff.wait_sum, row_ff.run_sum};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         in_phase_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         in_phase_ff  <= in_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      stamp_ff    <= stamp_in;
      inc_ff      <= inc_in;
      cur_ff      <= cur_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_SAME(a_phase_switch_only, clock, reset, in_phase_ff, kind_ff == KIND_SWITCH, "incoming phase outside a switch transaction")
   `ASSERT_NEXT(a_neg_skips_add, clock, reset, (state_ff == S_ADDS) && alu_y[STAMP_W-1], state_ff == S_WRITE, "negative elapsed time was accumulated")
   `ASSERT_NEXT(a_rsp_from_resp, clock, reset, (state_ff != S_RESP) && !rsp_valid_ff, !rsp_valid_ff, "result raised outside the response step")
   `ASSERT_NEXT(a_single_pass_done, clock, reset, (state_ff == S_WRITE) && (kind_ff != KIND_SWITCH), state_ff == S_IDLE, "extra pass after a single-slot transaction")

endmodule
